// ----- hdl/kblfp_pkg.sv -----
// Shared types, constants and helpers for the keypad link frame parser.
`default_nettype none

package kblfp_pkg;

    localparam logic [7:0] START_BYTE   = 8'hAA;
    localparam logic [7:0] END_BYTE     = 8'h55;
    localparam logic [7:0] ACK_FIRST    = 8'h6B;   // 'k'
    localparam logic [3:0] ACK_CHK_IDX  = 4'd9;    // index at which the ack check byte is due
    localparam logic [3:0] KEY_FLAG_IDX = 4'd2;
    localparam logic [3:0] KEY_CHK_IDX  = 4'd3;
    localparam logic [3:0] KEY_END_IDX  = 4'd4;

    localparam logic [2:0] PH_HUNT     = 3'd0;
    localparam logic [2:0] PH_FIRST    = 3'd1;
    localparam logic [2:0] PH_ACK_TEXT = 3'd2;
    localparam logic [2:0] PH_ACK_END  = 3'd3;
    localparam logic [2:0] PH_KEY_BODY = 3'd5;
    localparam logic [2:0] PH_KEY_END  = 3'd6;

    typedef struct packed {
        logic [2:0] phase;
        logic [3:0] idx;
        logic [7:0] xsum;
        logic       tmatch;
        logic [7:0] code;
        logic [7:0] flag;
    } parse_state_t;

    typedef struct packed {
        logic       key_valid;
        logic [7:0] key_code;
        logic [7:0] key_flag;
        logic       link_ack;
    } parse_result_t;

    localparam parse_state_t STATE_RESET = '{
        phase:  PH_HUNT,
        idx:    4'd0,
        xsum:   8'd0,
        tmatch: 1'b1,
        code:   8'd0,
        flag:   8'd0
    };

    // characters of "keyboard"
    function automatic logic [7:0] ack_char(input logic [2:0] pos);
        logic [7:0] c;
        case (pos)
            3'd0:    c = 8'h6B;
            3'd1:    c = 8'h65;
            3'd2:    c = 8'h79;
            3'd3:    c = 8'h62;
            3'd4:    c = 8'h6F;
            3'd5:    c = 8'h61;
            3'd6:    c = 8'h72;
            default: c = 8'h64;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

// ----- hdl/kblfp_step.sv -----
// Per-word frame parser update: next parse state and the result for one byte.
`default_nettype none

module kblfp_step (
    input  wire kblfp_pkg::parse_state_t  cur,
    input  wire logic [7:0]               rx_byte,
    output kblfp_pkg::parse_state_t       nxt,
    output kblfp_pkg::parse_result_t      res
);

    logic [3:0] idx_m1;

    assign idx_m1 = cur.idx - 4'd1;

    always_comb
    begin
        nxt = cur;
        res = '0;
        unique case (cur.phase)
            kblfp_pkg::PH_HUNT:
            begin
                if (rx_byte == kblfp_pkg::START_BYTE)
                begin
                    nxt       = kblfp_pkg::STATE_RESET;
                    nxt.idx   = 4'd1;
                    nxt.phase = kblfp_pkg::PH_FIRST;
                end
            end
            kblfp_pkg::PH_FIRST:
            begin
                nxt.code  = rx_byte;
                nxt.xsum  = cur.xsum ^ rx_byte;
                nxt.idx   = kblfp_pkg::KEY_FLAG_IDX;
                nxt.phase = (rx_byte == kblfp_pkg::ACK_FIRST) ? kblfp_pkg::PH_ACK_TEXT
                                                              : kblfp_pkg::PH_KEY_BODY;
            end
            kblfp_pkg::PH_ACK_TEXT:
            begin
                if (cur.idx < kblfp_pkg::ACK_CHK_IDX)
                begin
                    if (rx_byte != kblfp_pkg::ack_char(idx_m1[2:0]))
                        nxt.tmatch = 1'b0;
                    nxt.xsum = cur.xsum ^ rx_byte;
                    nxt.idx  = cur.idx + 4'd1;
                end
                else
                begin
                    nxt.phase = (rx_byte == cur.xsum && cur.tmatch) ? kblfp_pkg::PH_ACK_END
                                                                    : kblfp_pkg::PH_HUNT;
                end
            end
            kblfp_pkg::PH_ACK_END:
            begin
                res.link_ack = (rx_byte == kblfp_pkg::END_BYTE);
                nxt.phase    = kblfp_pkg::PH_HUNT;
            end
            kblfp_pkg::PH_KEY_BODY:
            begin
                if (cur.idx < kblfp_pkg::KEY_CHK_IDX)
                begin
                    nxt.flag = rx_byte;
                    nxt.xsum = cur.xsum ^ rx_byte;
                    nxt.idx  = kblfp_pkg::KEY_CHK_IDX;
                end
                else if (rx_byte == cur.xsum)
                begin
                    nxt.idx   = kblfp_pkg::KEY_END_IDX;
                    nxt.phase = kblfp_pkg::PH_KEY_END;
                end
                else
                begin
                    nxt.phase = kblfp_pkg::PH_HUNT;
                end
            end
            kblfp_pkg::PH_KEY_END:
            begin
                if (rx_byte == kblfp_pkg::END_BYTE)
                begin
                    res.key_valid = 1'b1;
                    res.key_code  = cur.code;
                    res.key_flag  = cur.flag;
                end
                nxt.phase = kblfp_pkg::PH_HUNT;
            end
            default:
            begin
                nxt.phase = kblfp_pkg::PH_HUNT;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- hdl/keypad_link_frame_parser_core.sv -----
// Top level of the keypad link frame parser: input register, parse state, result register.
`default_nettype none

// One received byte per word; every accepted word yields exactly one result word.
// A word is latched in the input register, then the parse update (one XOR, a few
// byte compares) runs combinationally into the result register, so the block
// sustains one word per clock while out_stall does not hold the result register.
// The result register holds while out_stall is high and it is valid; the input
// register keeps accepting until both are full; in_stall follows out_stall only
// when both stages are occupied. key_code and key_flag read zero unless key_valid is set.
module keypad_link_frame_parser_core (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [7:0] rx_byte,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic            key_valid,
    output logic [7:0]      key_code,
    output logic [7:0]      key_flag,
    output logic            link_ack
);

    logic                      s1_valid_reg;
    logic [7:0]                s1_byte_reg;
    kblfp_pkg::parse_state_t   state_reg;
    kblfp_pkg::parse_state_t   state_next;
    kblfp_pkg::parse_result_t  res_next;
    kblfp_pkg::parse_result_t  res_reg;
    logic                      out_valid_reg;
    logic                      adv;

    assign adv      = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = s1_valid_reg && !adv;

    kblfp_step u_step (
        .cur     (state_reg),
        .rx_byte (s1_byte_reg),
        .nxt     (state_next),
        .res     (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= kblfp_pkg::STATE_RESET;
        end
        else
        begin
            if (!in_stall)
                s1_valid_reg <= in_valid;
            if (adv)
            begin
                state_reg     <= state_next;
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
            s1_byte_reg <= rx_byte;
        if (adv)
            res_reg <= res_next;
    end

    assign out_valid = out_valid_reg;
    assign key_valid = res_reg.key_valid;
    assign key_code  = res_reg.key_code;
    assign key_flag  = res_reg.key_flag;
    assign link_ack  = res_reg.link_ack;

    a_one_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(key_valid && link_ack))
        else $error("key and ack reported together");

    a_no_k_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && key_valid |-> key_code != kblfp_pkg::ACK_FIRST)
        else $error("key code 'k' delivered");

    a_key_phase: assert property (@(posedge clk) disable iff (!rst_n)
        adv && res_next.key_valid |-> state_reg.phase == kblfp_pkg::PH_KEY_END)
        else $error("key result outside key end phase");

    a_ack_phase: assert property (@(posedge clk) disable iff (!rst_n)
        adv && res_next.link_ack |-> state_reg.phase == kblfp_pkg::PH_ACK_END)
        else $error("ack result outside ack end phase");

    a_hold_state: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(state_reg))
        else $error("parse state moved without a word");

endmodule

`default_nettype wire
